// ===== sv/mpss_pkg.sv =====
package mpss_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_DIVISOR  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DUTY       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FAILSAFE_EN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_DIR    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STALL_WARN_LIM = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_STALL_ERR_LIM  = 3'd6;

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SETPOINT = 1'b1;

  localparam logic [1:0] STALL_NORMAL = 2'd0;
  localparam logic [1:0] STALL_WARN   = 2'd1;
  localparam logic [1:0] STALL_ERROR  = 2'd2;

  // integral scale is 32: error scaled by a 5-bit shift
  localparam int INTEG_SHIFT = 5;
  localparam int INTEG_MAX   = 255 * 32;

  // |error| * 32 needs 21 bits
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/mpss_div.sv =====
module mpss_div (
  input  logic               clk,
  input  logic               rst,
  input  mpss_pkg::div_req_t req,
  output mpss_pkg::div_rsp_t rsp
);
  import mpss_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [7:0]           rem;
  logic [7:0]           dvs;
  logic [8:0]           trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
      quo  <= req.dividend;
      rem  <= '0;
      dvs  <= (req.divisor == 8'd0) ? 8'd1 : req.divisor;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        quo <= {quo[DIV_W-2:0], fits};
        rem <= fits ? 8'(trial - {1'b0, dvs}) : trial[7:0];
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done     = busy && (cnt == '0);
  assign rsp.quotient = quo;

endmodule

// ===== sv/motor_pi_speed_with_stall_guard_unit.sv =====
// Speed PI loop with stall guard for an H-bridge drive.
// Input stream: s_tuser selects the kind (0 control tick, 1 new setpoint),
// s_tdata carries the signed 16-bit speed or setpoint. One result per input
// transaction on the output stream: duty, direction lines, signed drive,
// stall state and a stall-state-change flag.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr on the
// clock edge; write only while no transaction is in flight.
// Steps: a setpoint transaction goes from accept straight to the output
// register; a control tick runs error, integral division in the restoring
// divider, integrate, drive and stall update, failsafe, and in stall error
// only the stall count-down and failsafe. One transaction is processed at a
// time: a new one is accepted only once the last result is registered.
// s_tready is high whenever the sequencer is idle, even while a result still
// waits in the output register; a stalled output holds its data and the
// sequencer waits in its last step until the output register is free.
// Reset (rst, synchronous) restores default register values, clears the
// loop state, the stall counter and the failsafe counter, and drops m_tvalid.
module motor_pi_speed_with_stall_guard_unit #(
  parameter int FAILSAFE_TICKS = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mpss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mpss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // value[15:0]
  input  logic                                s_tuser,  // cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // duty[7:0], dir_a[8], dir_b[9], signed_drive[18:10], stall_state[20:19],
  // stall_event[21], zero[23:22]
  output logic [23:0]                         m_tdata
);
  import mpss_pkg::*;

  localparam int TW = $clog2(FAILSAFE_TICKS + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_START, S_DIV, S_DRIVE, S_ERR_TICK, S_FAILSAFE, S_FINISH
  } state_t;

  state_t state;

  logic [7:0] prop_gain, integ_divisor, min_duty, stall_warn_lim, stall_err_lim;
  logic       failsafe_en, reverse_dir;

  logic signed [15:0] setpoint;
  logic signed [15:0] speed;
  logic signed [16:0] speed_error;
  logic signed [13:0] integral;
  logic signed [8:0]  drive_level;
  logic [7:0]         stall_count;
  logic [1:0]         stall_level;
  logic [TW-1:0]      ticks;
  logic               event_flag;
  logic               err_neg;
  logic signed [24:0] prop_term;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mpss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [16:0] err_mag;
  always_comb begin
    err_mag          = speed_error[16] ? 17'(-speed_error) : 17'(speed_error);
    div_req.start    = (state == S_DIV_START);
    div_req.dividend = {err_mag[15:0], {INTEG_SHIFT{1'b0}}};
    div_req.divisor  = integ_divisor;
  end

  // integrate and clamp
  logic signed [22:0] quo_s;
  logic signed [22:0] integ_sum;
  logic signed [13:0] integ_clamped;
  always_comb begin
    quo_s     = err_neg ? -$signed({2'b00, div_rsp.quotient})
                        :  $signed({2'b00, div_rsp.quotient});
    integ_sum = 23'(integral) + quo_s;
    if (integ_sum < -23'sd8160)      integ_clamped = -14'(INTEG_MAX);
    else if (integ_sum > 23'sd8160)  integ_clamped = 14'(INTEG_MAX);
    else                             integ_clamped = integ_sum[13:0];
  end

  // drive level and stall counter
  logic signed [13:0] integ_rnd;
  logic signed [8:0]  integ_term;
  logic signed [8:0]  offset;
  logic signed [25:0] pwm_sum;
  logic signed [8:0]  pwm;
  logic               stall_up;
  logic [7:0]         count_new;
  logic [8:0]         warn_m1;
  always_comb begin
    integ_rnd  = (integral + (integral[13] ? 14'sd31 : 14'sd0)) >>> INTEG_SHIFT;
    integ_term = integ_rnd[8:0];
    if (setpoint == 16'sd0)  offset = 9'sd0;
    else if (setpoint[15])   offset = -$signed({1'b0, min_duty});
    else                     offset =  $signed({1'b0, min_duty});
    pwm_sum = 26'(offset) + 26'(prop_term) + 26'(integ_term);
    if (pwm_sum < -26'sd255)      pwm = -9'sd255;
    else if (pwm_sum > 26'sd255)  pwm = 9'sd255;
    else                          pwm = pwm_sum[8:0];
    stall_up = ((speed < 16'sd5 && drive_level == 9'sd255) ||
                (speed > -16'sd5 && drive_level == -9'sd255)) &&
               (stall_count < stall_err_lim);
    if (stall_up)                 count_new = stall_count + 8'd1;
    else if (stall_count != 8'd0) count_new = stall_count - 8'd1;
    else                          count_new = stall_count;
    warn_m1 = {1'b0, stall_warn_lim} - 9'd1;
  end

  logic [7:0] out_mag;
  logic       out_fwd;
  always_comb begin
    out_mag = drive_level[8] ? 8'(-drive_level) : drive_level[7:0];
    out_fwd = ~drive_level[8] ^ reverse_dir;
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      prop_gain      <= 8'd50;
      integ_divisor  <= 8'd10;
      min_duty       <= 8'd25;
      failsafe_en    <= 1'b1;
      reverse_dir    <= 1'b0;
      stall_warn_lim <= 8'd10;
      stall_err_lim  <= 8'd20;
      setpoint       <= '0;
      speed_error    <= '0;
      integral       <= '0;
      drive_level    <= '0;
      stall_count    <= '0;
      stall_level    <= STALL_NORMAL;
      ticks          <= '0;
      event_flag     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_PROP_GAIN:      prop_gain      <= cfg_wdata;
          REG_INTEG_DIVISOR:  integ_divisor  <= cfg_wdata;
          REG_MIN_DUTY:       min_duty       <= cfg_wdata;
          REG_FAILSAFE_EN:    failsafe_en    <= cfg_wdata[0];
          REG_REVERSE_DIR:    reverse_dir    <= cfg_wdata[0];
          REG_STALL_WARN_LIM: stall_warn_lim <= cfg_wdata;
          REG_STALL_ERR_LIM:  stall_err_lim  <= cfg_wdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            event_flag <= 1'b0;
            if (s_tuser == CMD_SETPOINT) begin
              setpoint <= $signed(s_tdata);
              ticks    <= '0;
              if (s_tdata == 16'd0) begin
                speed_error <= '0;
                integral    <= '0;
                drive_level <= '0;
              end
              state <= S_FINISH;
            end else begin
              speed_error <= 17'(setpoint) - 17'($signed(s_tdata));
              speed       <= $signed(s_tdata);
              state       <= (stall_level == STALL_ERROR) ? S_ERR_TICK : S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          err_neg   <= speed_error[16];
          prop_term <= 25'(speed_error) * 25'($signed({1'b0, prop_gain}));
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            integral <= integ_clamped;
            state    <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          stall_count <= count_new;
          if ({1'b0, count_new} == warn_m1 && stall_count == stall_warn_lim) begin
            stall_level <= STALL_NORMAL;
            event_flag  <= 1'b1;
            drive_level <= pwm;
          end else if (count_new == stall_warn_lim && {1'b0, stall_count} == warn_m1) begin
            stall_level <= STALL_WARN;
            event_flag  <= 1'b1;
            drive_level <= pwm;
          end else if (count_new == stall_err_lim) begin
            stall_level <= STALL_ERROR;
            event_flag  <= 1'b1;
            speed_error <= '0;
            integral    <= '0;
            setpoint    <= '0;
            drive_level <= '0;
          end else begin
            drive_level <= pwm;
          end
          state <= S_FAILSAFE;
        end
        S_ERR_TICK: begin
          if (stall_count > 8'd1) begin
            stall_count <= stall_count - 8'd1;
          end else begin
            stall_count <= '0;
            stall_level <= STALL_NORMAL;
            event_flag  <= 1'b1;
          end
          state <= S_FAILSAFE;
        end
        S_FAILSAFE: begin
          if (failsafe_en && (ticks == TW'(FAILSAFE_TICKS) ||
                              ticks == TW'(FAILSAFE_TICKS - 1))) begin
            speed_error <= '0;
            integral    <= '0;
            setpoint    <= '0;
            drive_level <= '0;
          end
          if (ticks <= TW'(FAILSAFE_TICKS)) ticks <= ticks + 1'b1;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, event_flag, stall_level, drive_level,
                         ~out_fwd, out_fwd, out_mag};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
